// ----- src/tccs_pkg.sv -----
package tccs_pkg;

   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS = 64;
   localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
   localparam int ROWS_W = $clog2(MAX_ROWS + 1);

   localparam logic [7:0] SPACE_CODE = 8'h20;

   localparam logic [1:0] CMD_PUT = 2'd0;
   localparam logic [1:0] CMD_SET = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_COLUMNS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_ROWS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_ATTRIBUTE = 2'd2;

   localparam logic [7:0] TEXT_COLUMNS_RESET = 8'd80;
   localparam logic [6:0] TEXT_ROWS_RESET = 7'd25;
   localparam logic [7:0] TEXT_ATTRIBUTE_RESET = 8'd0;

   typedef logic [COL_W-1:0] col_type;
   typedef logic [ROW_W-1:0] row_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [COLS_W-1:0] cols_type;
   typedef logic [ROWS_W-1:0] rows_type;
   typedef logic [15:0] cell_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] char_code;
      logic [6:0] column;
      logic [5:0] row;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
      logic [6:0] cursor_column;
      logic [5:0] cursor_row;
      logic       scrolled;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic init_step;
      logic scroll_step;
      logic clear_step;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       put_scrolls;
      logic       sweep_done;
   } dp_status_type;

   function automatic cols_type cols_in_use(input logic [7:0] v);
      cols_type r;
      if (v == 8'd0) begin
         r = cols_type'(1);
      end else if (int'(v) > MAX_COLUMNS) begin
         r = cols_type'(MAX_COLUMNS);
      end else begin
         r = cols_type'(v);
      end
      return r;
   endfunction

   function automatic rows_type rows_in_use(input logic [6:0] v);
      rows_type r;
      if (v == 7'd0) begin
         r = rows_type'(1);
      end else if (int'(v) > MAX_ROWS) begin
         r = rows_type'(MAX_ROWS);
      end else begin
         r = rows_type'(v);
      end
      return r;
   endfunction

   function automatic int sat_index(input int v, input int limit);
      int r;
      if (v >= limit) begin
         r = limit - 1;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic addr_type cell_addr(input int col, input int row);
      return addr_type'(row * MAX_COLUMNS + col);
   endfunction

endpackage

// ----- src/tccs_ctrl.sv -----
module tccs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  tccs_pkg::dp_status_type status,
   output tccs_pkg::ctl_cmd_type   cmd
);

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            unique case (status.command)
               tccs_pkg::CMD_PUT, tccs_pkg::CMD_SET: begin
                  if (status.put_scrolls) begin
                     state_in = ST_SCROLL;
                  end else if (rsp_free) begin
                     cmd.load_rsp = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               tccs_pkg::CMD_READ: begin
                  state_in = ST_DONE;
               end
               tccs_pkg::CMD_CLEAR: begin
                  state_in = ST_CLEAR;
               end
            endcase
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/tccs_datapath.sv -----
module tccs_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [tccs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [7:0]                            csr_wdata,
   input  tccs_pkg::req_type                     req_payload,
   input  tccs_pkg::ctl_cmd_type                 cmd,
   output tccs_pkg::dp_status_type               status,
   output tccs_pkg::rsp_type                     rsp_payload
);

   logic [7:0] text_columns_ff;
   logic [6:0] text_rows_ff;
   logic [7:0] text_attribute_ff;

   tccs_pkg::cols_type cols_use;
   tccs_pkg::rows_type rows_use;

   tccs_pkg::req_type req_ff;

   tccs_pkg::col_type cur_col_ff;
   tccs_pkg::col_type cur_col_in;
   tccs_pkg::row_type cur_row_ff;
   tccs_pkg::row_type cur_row_in;

   tccs_pkg::col_type put_col;
   tccs_pkg::row_type put_row;
   logic              col_wraps;
   logic              row_wraps;
   logic              put_scrolls;

   tccs_pkg::col_type  sweep_col_ff;
   tccs_pkg::col_type  sweep_col_in;
   tccs_pkg::row_type  sweep_row_ff;
   tccs_pkg::row_type  sweep_row_in;
   logic               pend_ff;
   logic               pend_in;
   tccs_pkg::addr_type pend_addr_ff;
   tccs_pkg::addr_type pend_addr_in;
   logic               col_last;
   logic               row_last;
   logic               advance;
   logic               sweep_done;

   logic scroll_ff;
   logic scroll_in;

   tccs_pkg::cell_type cell_mem [tccs_pkg::CELL_COUNT];
   tccs_pkg::cell_type rd_ff;
   logic               mem_we;
   tccs_pkg::addr_type mem_waddr;
   tccs_pkg::cell_type mem_wdata;
   logic               mem_re;
   tccs_pkg::addr_type mem_raddr;

   tccs_pkg::rsp_type rsp_ff;
   tccs_pkg::rsp_type rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_columns_ff <= tccs_pkg::TEXT_COLUMNS_RESET;
         text_rows_ff <= tccs_pkg::TEXT_ROWS_RESET;
         text_attribute_ff <= tccs_pkg::TEXT_ATTRIBUTE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            tccs_pkg::CSR_TEXT_COLUMNS: begin
               text_columns_ff <= csr_wdata;
            end
            tccs_pkg::CSR_TEXT_ROWS: begin
               text_rows_ff <= csr_wdata[6:0];
            end
            tccs_pkg::CSR_TEXT_ATTRIBUTE: begin
               text_attribute_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign cols_use = tccs_pkg::cols_in_use(text_columns_ff);
   assign rows_use = tccs_pkg::rows_in_use(text_rows_ff);

   // The cursor may lie outside the screen after a resize, so a put first
   // pulls it back inside.
   assign put_col = tccs_pkg::col_type'(tccs_pkg::sat_index(int'(cur_col_ff), int'(cols_use)));
   assign put_row = tccs_pkg::row_type'(tccs_pkg::sat_index(int'(cur_row_ff), int'(rows_use)));
   assign col_wraps = (int'(put_col) + 1 >= int'(cols_use));
   assign row_wraps = (int'(put_row) + 1 >= int'(rows_use));
   assign put_scrolls = (req_ff.command == tccs_pkg::CMD_PUT) && col_wraps && row_wraps;

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (cmd.exec && req_ff.command == tccs_pkg::CMD_PUT) begin
         if (col_wraps) begin
            cur_col_in = '0;
            cur_row_in = row_wraps ? put_row : tccs_pkg::row_type'(int'(put_row) + 1);
         end else begin
            cur_col_in = tccs_pkg::col_type'(int'(put_col) + 1);
            cur_row_in = put_row;
         end
      end else if (cmd.exec && req_ff.command == tccs_pkg::CMD_SET) begin
         cur_col_in = tccs_pkg::col_type'(
            tccs_pkg::sat_index(int'(req_ff.column), int'(cols_use)));
         cur_row_in = tccs_pkg::row_type'(
            tccs_pkg::sat_index(int'(req_ff.row), int'(rows_use)));
      end
   end

   always_comb begin
      int lim_col;
      int lim_row;
      lim_col = cmd.clear_step ? int'(cols_use) : tccs_pkg::MAX_COLUMNS;
      lim_row = cmd.init_step ? tccs_pkg::MAX_ROWS : int'(rows_use);
      col_last = (int'(sweep_col_ff) == lim_col - 1);
      row_last = (int'(sweep_row_ff) == lim_row - 1);
   end

   // A scroll copies each cell from the row below, one cell per cycle, then
   // zeroes the last row after a drain. Writes trail the registered reads.
   always_comb begin
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re = 1'b0;
      mem_raddr = '0;
      advance = 1'b0;
      pend_in = pend_ff;
      pend_addr_in = pend_addr_ff;
      priority if (cmd.init_step) begin
         mem_we = 1'b1;
         mem_waddr = tccs_pkg::cell_addr(int'(sweep_col_ff), int'(sweep_row_ff));
         advance = 1'b1;
      end else if (cmd.exec) begin
         if (req_ff.command == tccs_pkg::CMD_PUT) begin
            mem_we = 1'b1;
            mem_waddr = tccs_pkg::cell_addr(int'(put_col), int'(put_row));
            mem_wdata = {text_attribute_ff, req_ff.char_code};
         end else if (req_ff.command == tccs_pkg::CMD_READ) begin
            mem_re = 1'b1;
            mem_raddr = tccs_pkg::cell_addr(
               tccs_pkg::sat_index(int'(req_ff.column), int'(cols_use)),
               tccs_pkg::sat_index(int'(req_ff.row), int'(rows_use)));
         end
      end else if (cmd.scroll_step) begin
         if (pend_ff) begin
            mem_we = 1'b1;
            mem_waddr = pend_addr_ff;
            mem_wdata = rd_ff;
         end
         if (!row_last) begin
            mem_re = 1'b1;
            mem_raddr = tccs_pkg::cell_addr(int'(sweep_col_ff), int'(sweep_row_ff) + 1);
            pend_in = 1'b1;
            pend_addr_in = tccs_pkg::cell_addr(int'(sweep_col_ff), int'(sweep_row_ff));
            advance = 1'b1;
         end else if (pend_ff) begin
            pend_in = 1'b0;
         end else begin
            mem_we = 1'b1;
            mem_waddr = tccs_pkg::cell_addr(int'(sweep_col_ff), int'(sweep_row_ff));
            advance = 1'b1;
         end
      end else if (cmd.clear_step) begin
         mem_we = 1'b1;
         mem_waddr = tccs_pkg::cell_addr(int'(sweep_col_ff), int'(sweep_row_ff));
         mem_wdata = {text_attribute_ff, tccs_pkg::SPACE_CODE};
         advance = 1'b1;
      end else begin
      end
   end

   assign sweep_done = (cmd.init_step || cmd.scroll_step || cmd.clear_step)
                       && advance && row_last && col_last;

   always_comb begin
      sweep_col_in = sweep_col_ff;
      sweep_row_in = sweep_row_ff;
      if (sweep_done) begin
         sweep_col_in = '0;
         sweep_row_in = '0;
      end else if (advance) begin
         if (col_last) begin
            sweep_col_in = '0;
            sweep_row_in = tccs_pkg::row_type'(int'(sweep_row_ff) + 1);
         end else begin
            sweep_col_in = tccs_pkg::col_type'(int'(sweep_col_ff) + 1);
         end
      end
   end

   assign scroll_in = cmd.exec ? put_scrolls : scroll_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= cell_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         sweep_col_ff <= '0;
         sweep_row_ff <= '0;
         pend_ff <= 1'b0;
         scroll_ff <= 1'b0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         sweep_col_ff <= sweep_col_in;
         sweep_row_ff <= sweep_row_in;
         pend_ff <= pend_in;
         scroll_ff <= scroll_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (req_ff.command == tccs_pkg::CMD_PUT) begin
         rsp_in.cell_char = req_ff.char_code;
         rsp_in.cell_attr = text_attribute_ff;
         rsp_in.scrolled = scroll_in;
      end else if (req_ff.command == tccs_pkg::CMD_READ) begin
         rsp_in.cell_char = rd_ff[7:0];
         rsp_in.cell_attr = rd_ff[15:8];
      end
      rsp_in.cursor_column = 7'(cur_col_in);
      rsp_in.cursor_row = 6'(cur_row_in);
   end

   assign status.command = req_ff.command;
   assign status.put_scrolls = put_scrolls;
   assign status.sweep_done = sweep_done;
   assign rsp_payload = rsp_ff;

endmodule

// ----- src/text_console_cursor_scroll_core.sv -----
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  tccs_pkg::req_type
// rsp       out        rsp_valid/rsp_stall  tccs_pkg::rsp_type
// csr       in         csr_write            csr_index, csr_wdata
//
// Beats are worked on one at a time: req_stall stays high until the
// result is loaded. Clear screen sweeps rows times columns cells and a put
// that scrolls sweeps rows times 128 cells, one cell per cycle but for a
// drain pause in a scroll. After reset all 8192 cells are zeroed before
// the first beat is taken. A stalled result waits in the output register
// while the next beat is taken and worked on.
module text_console_cursor_scroll_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tccs_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tccs_pkg::rsp_type                rsp_payload,
   input  logic                             csr_write,
   input  logic [tccs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);

   tccs_pkg::ctl_cmd_type   cmd;
   tccs_pkg::dp_status_type status;

   tccs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tccs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("a second beat was taken right after the first");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.scrolled |-> rsp_payload.cursor_column == 7'd0)
      else $error("scrolled result with the cursor off column zero");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam logic [tccs_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 50000;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_COUNT = 6;

   localparam int SEND_GAP_PCT [3] = '{17, 76, 0};
   localparam int RSP_STALL_PCT [3] = '{76, 17, 0};

   localparam logic [7:0] PHASE_COLUMNS [PHASE_COUNT] =
      '{8'd8, 8'hFF, 8'd1, 8'd5, 8'd13, 8'd128};
   localparam logic [7:0] PHASE_ROWS [PHASE_COUNT] =
      '{8'd4, 8'd1, 8'd5, 8'hA8, 8'd7, 8'd64};
   localparam logic [7:0] PHASE_ATTR [PHASE_COUNT] =
      '{8'h1E, 8'h70, 8'h0F, 8'hC3, 8'hFF, 8'h5A};
   localparam int PHASE_BEATS [PHASE_COUNT] = '{250, 250, 250, 200, 250, 50};

   typedef struct packed {
      logic                             is_csr;
      logic [tccs_pkg::CSR_INDEX_W-1:0] csr_idx;
      logic [7:0]                       csr_data;
      tccs_pkg::req_type                beat;
      logic                             typed;
      tccs_pkg::rsp_type                want;
   } script_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   tccs_pkg::req_type                req_payload = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   tccs_pkg::rsp_type                rsp_payload;
   logic                             csr_write = 1'b0;
   logic [tccs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]                       csr_wdata = '0;

   int send_gap_pct = SEND_GAP_PCT[0];
   int rsp_stall_pct = RSP_STALL_PCT[0];
   int mismatch_count = 0;
   int quiet_cycles = 0;

   tccs_pkg::rsp_type expected_rsp [$];
   tccs_pkg::rsp_type head_rsp;

   logic [7:0] char_mem [tccs_pkg::CELL_COUNT];
   logic [7:0] attr_mem [tccs_pkg::CELL_COUNT];
   int         cursor_x;
   int         cursor_y;
   logic [7:0] cfg_columns;
   logic [6:0] cfg_rows;
   logic [7:0] cfg_attr;

   text_console_cursor_scroll_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int cols_active();
      if (cfg_columns == 8'd0) return 1;
      if (int'(cfg_columns) > tccs_pkg::MAX_COLUMNS) return tccs_pkg::MAX_COLUMNS;
      return int'(cfg_columns);
   endfunction

   function automatic int rows_active();
      if (cfg_rows == 7'd0) return 1;
      if (int'(cfg_rows) > tccs_pkg::MAX_ROWS) return tccs_pkg::MAX_ROWS;
      return int'(cfg_rows);
   endfunction

   function automatic int clamp_to(input int v, input int limit);
      return (v >= limit) ? limit - 1 : v;
   endfunction

   task automatic console_step(input tccs_pkg::req_type r, output tccs_pkg::rsp_type o);
      int cols;
      int rows;
      int x;
      int y;
      int base;
      int i;
      cols = cols_active();
      rows = rows_active();
      o = '0;
      unique case (r.command)
         tccs_pkg::CMD_PUT: begin
            x = clamp_to(cursor_x, cols);
            y = clamp_to(cursor_y, rows);
            char_mem[y * tccs_pkg::MAX_COLUMNS + x] = r.char_code;
            attr_mem[y * tccs_pkg::MAX_COLUMNS + x] = cfg_attr;
            o.cell_char = r.char_code;
            o.cell_attr = cfg_attr;
            x++;
            if (x >= cols) begin
               x = 0;
               y++;
               if (y >= rows) begin
                  base = (rows - 1) * tccs_pkg::MAX_COLUMNS;
                  for (i = 0; i < base; i++) begin
                     char_mem[i] = char_mem[i + tccs_pkg::MAX_COLUMNS];
                     attr_mem[i] = attr_mem[i + tccs_pkg::MAX_COLUMNS];
                  end
                  for (i = 0; i < tccs_pkg::MAX_COLUMNS; i++) begin
                     char_mem[base + i] = 8'h00;
                     attr_mem[base + i] = 8'h00;
                  end
                  y = rows - 1;
                  o.scrolled = 1'b1;
               end
            end
            cursor_x = x;
            cursor_y = y;
         end
         tccs_pkg::CMD_SET: begin
            cursor_x = clamp_to(int'(r.column), cols);
            cursor_y = clamp_to(int'(r.row), rows);
         end
         tccs_pkg::CMD_READ: begin
            base = clamp_to(int'(r.row), rows) * tccs_pkg::MAX_COLUMNS
                   + clamp_to(int'(r.column), cols);
            o.cell_char = char_mem[base];
            o.cell_attr = attr_mem[base];
         end
         tccs_pkg::CMD_CLEAR: begin
            for (y = 0; y < rows; y++) begin
               for (x = 0; x < cols; x++) begin
                  char_mem[y * tccs_pkg::MAX_COLUMNS + x] = tccs_pkg::SPACE_CODE;
                  attr_mem[y * tccs_pkg::MAX_COLUMNS + x] = cfg_attr;
               end
            end
         end
      endcase
      o.cursor_column = cursor_x[6:0];
      o.cursor_row = cursor_y[5:0];
   endtask

   function automatic script_row_type beat_row(input logic [1:0] cmd,
                                               input logic [7:0] ch,
                                               input logic [6:0] col,
                                               input logic [5:0] row);
      script_row_type s;
      s = '0;
      s.beat.command = cmd;
      s.beat.char_code = ch;
      s.beat.column = col;
      s.beat.row = row;
      return s;
   endfunction

   function automatic script_row_type beat_row_exp(input logic [1:0] cmd,
                                                   input logic [7:0] ch,
                                                   input logic [6:0] col,
                                                   input logic [5:0] row,
                                                   input logic [7:0] got_char,
                                                   input logic [7:0] got_attr,
                                                   input logic [6:0] cur_col,
                                                   input logic [5:0] cur_row,
                                                   input logic did_scroll);
      script_row_type s;
      s = beat_row(cmd, ch, col, row);
      s.typed = 1'b1;
      s.want = '{got_char, got_attr, cur_col, cur_row, did_scroll};
      return s;
   endfunction

   function automatic script_row_type csr_row(input logic [tccs_pkg::CSR_INDEX_W-1:0] idx,
                                              input logic [7:0] data);
      script_row_type s;
      s = '0;
      s.is_csr = 1'b1;
      s.csr_idx = idx;
      s.csr_data = data;
      return s;
   endfunction

   function automatic tccs_pkg::req_type random_beat();
      tccs_pkg::req_type r;
      int pick;
      int cols;
      int rows;
      cols = cols_active();
      rows = rows_active();
      pick = $urandom_range(0, 99);
      r.char_code = 8'($urandom_range(0, 255));
      r.column = 7'($urandom_range(0, 127));
      r.row = 6'($urandom_range(0, 63));
      if (pick < 55) begin
         r.command = tccs_pkg::CMD_PUT;
      end else if (pick < 70) begin
         r.command = tccs_pkg::CMD_SET;
         if ($urandom_range(0, 1) == 1) begin
            r.row = 6'(rows - 1);
            r.column = 7'(cols - 1 - $urandom_range(0, (cols > 4) ? 3 : cols - 1));
         end
      end else if (pick < 96) begin
         r.command = tccs_pkg::CMD_READ;
         if ($urandom_range(0, 1) == 1) begin
            r.column = 7'($urandom_range(0, cols - 1));
            r.row = 6'($urandom_range(0, rows - 1));
         end
      end else begin
         r.command = tccs_pkg::CMD_CLEAR;
      end
      return r;
   endfunction

   task automatic send_beat(input tccs_pkg::req_type r, input logic typed,
                            input tccs_pkg::rsp_type typed_rsp);
      tccs_pkg::rsp_type predicted;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      console_step(r, predicted);
      expected_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic write_reg(input logic [tccs_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] data);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      unique case (idx)
         tccs_pkg::CSR_TEXT_COLUMNS: cfg_columns = data;
         tccs_pkg::CSR_TEXT_ROWS: cfg_rows = data[6:0];
         tccs_pkg::CSR_TEXT_ATTRIBUTE: cfg_attr = data;
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input tccs_pkg::rsp_type want,
                                  input tccs_pkg::rsp_type got);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("mismatch (%s) at %0t: expected char %h attr %h col %0d row %0d scr %b,",
                  what, $realtime, want.cell_char, want.cell_attr, want.cursor_column,
                  want.cursor_row, want.scrolled,
                  " got char %h attr %h col %0d row %0d scr %b",
                  got.cell_char, got.cell_attr, got.cursor_column, got.cursor_row,
                  got.scrolled);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("no result pending", '0, rsp_payload);
         end else begin
            head_rsp = expected_rsp.pop_front();
            if (rsp_payload.cell_char !== head_rsp.cell_char
                || rsp_payload.cell_attr !== head_rsp.cell_attr
                || rsp_payload.cursor_column !== head_rsp.cursor_column
                || rsp_payload.cursor_row !== head_rsp.cursor_row
                || rsp_payload.scrolled !== head_rsp.scrolled) begin
               report_mismatch("wrong result", head_rsp, rsp_payload);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      script_row_type directed [$];
      script_row_type s;
      int p;
      int n;
      int i;
      for (i = 0; i < tccs_pkg::CELL_COUNT; i++) begin
         char_mem[i] = 8'h00;
         attr_mem[i] = 8'h00;
      end
      cursor_x = 0;
      cursor_y = 0;
      cfg_columns = tccs_pkg::TEXT_COLUMNS_RESET;
      cfg_rows = tccs_pkg::TEXT_ROWS_RESET;
      cfg_attr = tccs_pkg::TEXT_ATTRIBUTE_RESET;

      // The first rows run at the reset size of 80 by 25 with attribute zero.
      directed = '{
         beat_row_exp(tccs_pkg::CMD_READ, 8'h00, 7'd127, 6'd63,
                      8'h00, 8'h00, 7'd0, 6'd0, 1'b0),
         beat_row_exp(tccs_pkg::CMD_SET, 8'h00, 7'd127, 6'd63,
                      8'h00, 8'h00, 7'd79, 6'd24, 1'b0),
         beat_row_exp(tccs_pkg::CMD_PUT, 8'hFF, 7'd0, 6'd0,
                      8'hFF, 8'h00, 7'd0, 6'd24, 1'b1),
         beat_row(tccs_pkg::CMD_READ, 8'h00, 7'd79, 6'd23),
         csr_row(tccs_pkg::CSR_TEXT_ATTRIBUTE, 8'hFF),
         beat_row_exp(tccs_pkg::CMD_PUT, 8'h00, 7'd127, 6'd63,
                      8'h00, 8'hFF, 7'd1, 6'd24, 1'b0),
         beat_row_exp(tccs_pkg::CMD_CLEAR, 8'hFF, 7'd127, 6'd63,
                      8'h00, 8'h00, 7'd1, 6'd24, 1'b0),
         beat_row_exp(tccs_pkg::CMD_READ, 8'h00, 7'd0, 6'd0,
                      8'h20, 8'hFF, 7'd1, 6'd24, 1'b0),
         beat_row_exp(tccs_pkg::CMD_READ, 8'h00, 7'd127, 6'd63,
                      8'h20, 8'hFF, 7'd1, 6'd24, 1'b0),
         csr_row(tccs_pkg::CSR_TEXT_COLUMNS, 8'h00),
         csr_row(tccs_pkg::CSR_TEXT_ROWS, 8'h00),
         csr_row(CSR_UNUSED, 8'hFF),
         beat_row_exp(tccs_pkg::CMD_PUT, 8'h41, 7'd0, 6'd0,
                      8'h41, 8'hFF, 7'd0, 6'd0, 1'b1),
         beat_row_exp(tccs_pkg::CMD_READ, 8'h00, 7'd5, 6'd5,
                      8'h00, 8'h00, 7'd0, 6'd0, 1'b0),
         csr_row(tccs_pkg::CSR_TEXT_COLUMNS, 8'hFF),
         csr_row(tccs_pkg::CSR_TEXT_ROWS, 8'hFF),
         beat_row_exp(tccs_pkg::CMD_SET, 8'h00, 7'd127, 6'd63,
                      8'h00, 8'h00, 7'd127, 6'd63, 1'b0),
         beat_row_exp(tccs_pkg::CMD_PUT, 8'h7E, 7'd0, 6'd0,
                      8'h7E, 8'hFF, 7'd0, 6'd63, 1'b1),
         beat_row(tccs_pkg::CMD_READ, 8'h00, 7'd127, 6'd62),
         beat_row_exp(tccs_pkg::CMD_CLEAR, 8'h00, 7'd0, 6'd0,
                      8'h00, 8'h00, 7'd0, 6'd63, 1'b0),
         csr_row(tccs_pkg::CSR_TEXT_COLUMNS, 8'd3),
         csr_row(tccs_pkg::CSR_TEXT_ROWS, 8'd2),
         csr_row(tccs_pkg::CSR_TEXT_ATTRIBUTE, 8'h00),
         beat_row_exp(tccs_pkg::CMD_PUT, 8'h80, 7'd0, 6'd0,
                      8'h80, 8'h00, 7'd1, 6'd1, 1'b0),
         beat_row(tccs_pkg::CMD_PUT, 8'h01, 7'd0, 6'd0),
         beat_row(tccs_pkg::CMD_PUT, 8'h02, 7'd0, 6'd0),
         beat_row(tccs_pkg::CMD_READ, 8'h00, 7'd2, 6'd0),
         beat_row(tccs_pkg::CMD_READ, 8'h00, 7'd0, 6'd1),
         beat_row_exp(tccs_pkg::CMD_SET, 8'h00, 7'd64, 6'd32,
                      8'h00, 8'h00, 7'd2, 6'd1, 1'b0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k]) begin
         s = directed[k];
         if (s.is_csr) begin
            write_reg(s.csr_idx, s.csr_data);
         end else begin
            send_beat(s.beat, s.typed, s.want);
         end
      end

      for (p = 0; p < PHASE_COUNT; p++) begin
         write_reg(tccs_pkg::CSR_TEXT_COLUMNS, PHASE_COLUMNS[p]);
         write_reg(tccs_pkg::CSR_TEXT_ROWS, PHASE_ROWS[p]);
         write_reg(tccs_pkg::CSR_TEXT_ATTRIBUTE, PHASE_ATTR[p]);
         send_gap_pct = SEND_GAP_PCT[p / 2];
         rsp_stall_pct = RSP_STALL_PCT[p / 2];
         for (n = 0; n < PHASE_BEATS[p]; n++) begin
            send_beat(random_beat(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
